// ----- hdl/hfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfa_pkg
// Types and codes shared by the hole fit allocator: field types, item
// opcodes, placement policies and configuration register indexes.
// ----------------------------------------------------------------------------
package hfa_pkg;

	localparam int OPCODE_W   = 2;
	localparam int SLOT_W     = 5;
	localparam int AMOUNT_W   = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 6;

	typedef logic [OPCODE_W-1:0]   opcode_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [AMOUNT_W-1:0]   amount_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [1:0]            fit_mode_t;
	typedef logic [5:0]            hole_count_t;

	// Item opcodes
	localparam opcode_t OP_LOAD  = 2'd0;
	localparam opcode_t OP_ALLOC = 2'd1;
	localparam opcode_t OP_FREE  = 2'd2;

	// Placement policies; the unused code behaves as first fit
	localparam fit_mode_t FIT_FIRST = 2'd0;
	localparam fit_mode_t FIT_BEST  = 2'd1;
	localparam fit_mode_t FIT_WORST = 2'd2;

	// Configuration register indexes
	localparam cfg_idx_t CFG_FIT_MODE   = 4'd0;
	localparam cfg_idx_t CFG_HOLE_COUNT = 4'd1;

endpackage
`default_nettype wire

// ----- hdl/hole_fit_allocator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hole_fit_allocator_core
// Hole table allocator: first, best or worst fit search over a table of hole
// sizes held in one memory, with the taken marks held in a second memory.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    opcode, slot, amount
// out       output     out_valid / out_ready  granted, chosen_hole, leftover
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An allocate request makes one memory read per active hole, waits out the
// read latency, drains the compare and then writes the taken mark of the
// chosen hole. A free item and reset each start a clearing pass over every
// entry of the taken mark memory, during which no item is taken in;
// configuration writes are always taken. The result waits in an output
// register, so the next item is taken in while it is still unread; a
// finished search stalls only while that register is still full.
// ----------------------------------------------------------------------------
module hole_fit_allocator_core #(
	parameter int HOLE_SLOTS = 32,
	parameter int SIZE_BITS  = 24
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire hfa_pkg::opcode_t    opcode,
	input  wire hfa_pkg::slot_t      slot,
	input  wire hfa_pkg::amount_t    amount,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic                     granted,
	output hfa_pkg::slot_t           chosen_hole,
	output hfa_pkg::amount_t         leftover,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire hfa_pkg::cfg_idx_t   cfg_index,
	input  wire hfa_pkg::cfg_data_t  cfg_data
);
	import hfa_pkg::*;

	localparam int IDX_W = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(HOLE_SLOTS + 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	typedef logic [SIZE_BITS-1:0] size_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	state_t      state_q;
	fit_mode_t   fit_mode_q;
	hole_count_t hole_count_q;

	cnt_t  idx_q;
	cnt_t  n_q;
	size_t req_q;
	logic  found_q;
	idx_t  pick_q;
	size_t best_q;

	logic  rd_vld_s1;
	idx_t  rd_idx_s1;
	size_t size_rd_s1;
	logic  taken_rd_s1;

	logic    out_valid_q;
	logic    granted_q;
	slot_t   chosen_q;
	amount_t leftover_q;

	size_t size_mem  [HOLE_SLOTS];
	logic  taken_mem [HOLE_SLOTS];

	logic  in_xfer;
	logic  load_we;
	cnt_t  act_cnt;
	idx_t  rd_addr;
	logic  issue;
	logic  adequate;
	logic  take;
	logic  out_free;
	logic  taken_we;
	idx_t  taken_wa;
	logic  taken_wd;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign load_we   = in_xfer && (opcode == OP_LOAD) && (32'(slot) < 32'(HOLE_SLOTS));

	always_comb begin
		if (32'(hole_count_q) > 32'(HOLE_SLOTS)) begin
			act_cnt = CNT_W'(HOLE_SLOTS);
		end else begin
			act_cnt = CNT_W'(hole_count_q);
		end
	end

	assign rd_addr = idx_q[IDX_W-1:0];
	assign issue   = (state_q == ST_SCAN) && (idx_q < n_q);

	// A free hole that is big enough replaces the current pick only when it is
	// the first one seen or strictly better under the policy in force.
	assign adequate = rd_vld_s1 && !taken_rd_s1 && (size_rd_s1 >= req_q);
	assign take     = adequate && (!found_q
		|| ((fit_mode_q == FIT_BEST)  && (size_rd_s1 < best_q))
		|| ((fit_mode_q == FIT_WORST) && (size_rd_s1 > best_q)));

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		taken_we = 1'b0;
		taken_wa = idx_q[IDX_W-1:0];
		taken_wd = 1'b0;
		if (state_q == ST_CLEAR) begin
			taken_we = 1'b1;
		end else if ((state_q == ST_FINISH) && found_q) begin
			taken_we = 1'b1;
			taken_wa = pick_q;
			taken_wd = 1'b1;
		end
	end

	// Memories
	always_ff @(posedge clk) begin
		if (load_we) begin
			size_mem[IDX_W'(slot)] <= SIZE_BITS'(amount);
		end
		size_rd_s1 <= size_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (taken_we) begin
			taken_mem[taken_wa] <= taken_wd;
		end
		taken_rd_s1 <= taken_mem[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= FIT_FIRST;
			hole_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIT_MODE:   fit_mode_q   <= cfg_data[1:0];
				CFG_HOLE_COUNT: hole_count_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (in_xfer && (opcode == OP_ALLOC)) begin
			req_q <= SIZE_BITS'(amount);
			n_q   <= act_cnt;
		end
		if (take) begin
			pick_q <= rd_idx_s1;
			best_q <= size_rd_s1;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			granted_q <= found_q;
			if (found_q) begin
				chosen_q   <= SLOT_W'(pick_q);
				leftover_q <= AMOUNT_W'(size_t'(best_q - req_q));
			end else begin
				chosen_q   <= '0;
				leftover_q <= '0;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == CNT_W'(HOLE_SLOTS - 1)) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					idx_q     <= '0;
					found_q   <= 1'b0;
					if (in_xfer) begin
						if (opcode == OP_ALLOC) begin
							state_q <= ST_SCAN;
						end else if (opcode == OP_FREE) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = granted_q;
	assign chosen_hole = chosen_q;
	assign leftover    = leftover_q;

	// Assertions
	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("read data pending outside a search");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= n_q))
		else $error("search index beyond the active hole count");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && found_q) |-> (CNT_W'(pick_q) < n_q))
		else $error("chosen hole outside the active range");

	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && found_q) |-> (best_q >= req_q))
		else $error("chosen hole smaller than the request");

	a_alloc_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (opcode == OP_ALLOC)) |=> (state_q == ST_SCAN))
		else $error("allocate transfer did not start a search");

endmodule
`default_nettype wire

// ----- verif/tb_hole_fit_allocator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hole_fit_allocator_core
// Self-checking bench for the hole fit allocator. A short table of directed
// items covers the corner cases, and random phases follow, each under its own
// policy and hole count. Every allocation result is compared with a typed grant
// or a model of the hole table kept in the bench, while both channels stall at random.
// ----------------------------------------------------------------------------
module tb_hole_fit_allocator_core;
	import hfa_pkg::*;

	localparam int HOLE_SLOTS    = 32;
	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 2 * HOLE_SLOTS + 8;
	localparam int RANDOM_ITEMS  = 510;

	// Codes that the package leaves unnamed
	localparam opcode_t   OP_NONE   = 2'd3;
	localparam fit_mode_t FIT_UNDEF = 2'd3;
	localparam cfg_idx_t  CFG_SPARE = 4'd15;

	typedef struct packed {
		logic    granted;
		slot_t   hole;
		amount_t leftover;
	} grant_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		opcode_t   op;
		slot_t     slot;
		amount_t   amount;
		cfg_idx_t  reg_idx;
		cfg_data_t reg_val;
		bit        typed;
		grant_t    grant;
	} row_t;

	localparam grant_t NO_GRANT = '0;

	// Where the grant is obvious it is typed in; otherwise the model decides.
	localparam row_t DIRECTED [28] = '{
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd0,        CFG_FIT_MODE,   6'd0, 1'b1, NO_GRANT},
		'{ROW_CFG,  OP_LOAD,  5'd0,  24'd0,        CFG_HOLE_COUNT, 6'd4, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_LOAD,  5'd0,  24'd100,      CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_LOAD,  5'd1,  24'hFFFFFF,   CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_LOAD,  5'd2,  24'd0,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_LOAD,  5'd3,  24'd50,       CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd0,        CFG_FIT_MODE,   6'd0, 1'b1,
			'{1'b1, 5'd0, 24'd100}},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'hFFFFFF,   CFG_FIT_MODE,   6'd0, 1'b1,
			'{1'b1, 5'd1, 24'd0}},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'hFFFFFF,   CFG_FIT_MODE,   6'd0, 1'b1, NO_GRANT},
		'{ROW_ITEM, OP_FREE,  5'd0,  24'd0,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_CFG,  OP_LOAD,  5'd0,  24'd0,        CFG_FIT_MODE,
			{4'b0000, FIT_BEST}, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd40,       CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		// Reloading a taken hole must leave it taken.
		'{ROW_ITEM, OP_LOAD,  5'd3,  24'd7,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd0,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_CFG,  OP_LOAD,  5'd0,  24'd0,        CFG_FIT_MODE,
			{4'b0000, FIT_WORST}, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd1,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_NONE,  5'd31, 24'hFFFFFF,   CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd1,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd0,        CFG_FIT_MODE,   6'd0, 1'b1, NO_GRANT},
		'{ROW_ITEM, OP_FREE,  5'd0,  24'd0,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_LOAD,  5'd1,  24'd100,      CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_LOAD,  5'd2,  24'd100,      CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd100,      CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_CFG,  OP_LOAD,  5'd0,  24'd0,        CFG_FIT_MODE,
			{4'b0000, FIT_UNDEF}, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd5,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT},
		'{ROW_CFG,  OP_LOAD,  5'd0,  24'd0,        CFG_SPARE,      6'h3F, 1'b0, NO_GRANT},
		'{ROW_CFG,  OP_LOAD,  5'd0,  24'd0,        CFG_FIT_MODE,
			{4'b1111, FIT_BEST}, 1'b0, NO_GRANT},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  24'd6,        CFG_FIT_MODE,   6'd0, 1'b0, NO_GRANT}
	};

	localparam hole_count_t EDGE_COUNTS [6] = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd33, 6'd31};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	opcode_t   opcode    = OP_LOAD;
	slot_t     slot      = '0;
	amount_t   amount    = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	logic      granted;
	slot_t     chosen_hole;
	amount_t   leftover;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = CFG_FIT_MODE;
	cfg_data_t cfg_data  = '0;

	// Bench copy of the hole table and the registers
	amount_t     hole_len    [HOLE_SLOTS];
	bit          hole_busy   [HOLE_SLOTS];
	bit          hole_loaded [HOLE_SLOTS];
	fit_mode_t   policy       = FIT_FIRST;
	hole_count_t holes_in_use = '0;

	grant_t      pending_grants [$];
	bit          quiet_phase  = 1'b0;
	amount_t     size_mask    = '1;
	int unsigned stall_left   = 0;
	int unsigned fail_count   = 0;
	int unsigned items_taken  = 0;
	int unsigned requests     = 0;
	int unsigned grants_seen  = 0;
	int unsigned reg_writes   = 0;

	hole_fit_allocator_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.slot        (slot),
		.amount      (amount),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.granted     (granted),
		.chosen_hole (chosen_hole),
		.leftover    (leftover),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one item to the bench table and returns 1 when it yields a grant result.
	function automatic bit predict_grant(input opcode_t op, input slot_t s, input amount_t a,
			output grant_t g);
		int  span;
		int  pick;
		bit  found;
		g     = NO_GRANT;
		span  = (holes_in_use > HOLE_SLOTS) ? HOLE_SLOTS : int'(holes_in_use);
		pick  = 0;
		found = 1'b0;
		case (op)
		OP_LOAD: begin
			hole_len[s]    = a;
			hole_loaded[s] = 1'b1;
			return 1'b0;
		end
		OP_FREE: begin
			foreach (hole_busy[i])
				hole_busy[i] = 1'b0;
			return 1'b0;
		end
		OP_ALLOC: begin
			// Under first fit the earliest hit is never displaced.
			for (int i = 0; i < span; i++) begin
				if (!hole_busy[i] && hole_len[i] >= a) begin
					if (!found) begin
						found = 1'b1;
						pick  = i;
					end else if (policy == FIT_BEST && hole_len[i] < hole_len[pick]) begin
						pick = i;
					end else if (policy == FIT_WORST && hole_len[i] > hole_len[pick]) begin
						pick = i;
					end
				end
			end
			if (found) begin
				hole_busy[pick] = 1'b1;
				g.granted       = 1'b1;
				g.hole          = slot_t'(pick);
				g.leftover      = hole_len[pick] - a;
			end
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (quiet_phase || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic amount_t draw_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		if (r < 6)
			return '1;
		return amount_t'($urandom) & size_mask;
	endfunction

	task automatic send_request(input opcode_t op, input slot_t s, input amount_t a,
			input bit typed, input grant_t typed_grant);
		grant_t      g;
		int unsigned gap;
		in_valid <= 1'b1;
		opcode   <= op;
		slot     <= s;
		amount   <= a;
		do @(posedge clk); while (!in_ready);
		items_taken++;
		if (predict_grant(op, s, a, g)) begin
			pending_grants.push_back(typed ? typed_grant : g);
			requests++;
		end
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_FIT_MODE:   policy = val[1:0];
		CFG_HOLE_COUNT: holes_in_use = val;
		default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Waits out every outstanding grant plus a clearing pass and a full search.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(99) < 30)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin : grant_check
		grant_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0b/%0d/%0d", $time,
					granted, chosen_hole, leftover);
				fail_count++;
			end else begin
				want = pending_grants.pop_front();
				if (granted !== want.granted) begin
					$display("%0t: granted expected %0b actual %0b", $time,
						want.granted, granted);
					fail_count++;
				end
				if (chosen_hole !== want.hole) begin
					$display("%0t: chosen_hole expected %0d actual %0d", $time,
						want.hole, chosen_hole);
					fail_count++;
				end
				if (leftover !== want.leftover) begin
					$display("%0t: leftover expected %0d actual %0d", $time,
						want.leftover, leftover);
					fail_count++;
				end
				if (granted === 1'b1)
					grants_seen++;
			end
		end
	end

	initial begin
		int unsigned random_items;
		int unsigned phase;
		int unsigned r;
		int          span_now;
		bit          hole_missing;
		slot_t       missing_slot;
		fit_mode_t   mode;
		hole_count_t count;

		random_items = 0;
		phase        = 0;
		foreach (hole_len[i]) begin
			hole_len[i]    = '0;
			hole_busy[i]   = 1'b0;
			hole_loaded[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < $size(DIRECTED); k++) begin
			if (DIRECTED[k].kind == ROW_CFG) begin
				settle_idle();
				write_reg(DIRECTED[k].reg_idx, DIRECTED[k].reg_val);
			end else begin
				send_request(DIRECTED[k].op, DIRECTED[k].slot, DIRECTED[k].amount,
					DIRECTED[k].typed, DIRECTED[k].grant);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			settle_idle();
			mode  = (phase < 4) ? fit_mode_t'(phase) : fit_mode_t'($urandom_range(3));
			count = (phase < 6) ? EDGE_COUNTS[phase] : hole_count_t'($urandom_range(63));
			write_reg(CFG_FIT_MODE, {4'($urandom), mode});
			write_reg(CFG_HOLE_COUNT, count);
			if ($urandom_range(3) == 0)
				write_reg(cfg_idx_t'($urandom_range(2 ** CFG_IDX_W - 1, CFG_HOLE_COUNT + 1)),
					cfg_data_t'($urandom));
			quiet_phase = ($urandom_range(4) == 0);
			// Narrow size ranges make ties between holes common.
			case ((phase == 0) ? 3 : $urandom_range(3))
			0:       size_mask = 24'h00000F;
			1:       size_mask = 24'h0000FF;
			2:       size_mask = 24'h00FFFF;
			default: size_mask = 24'hFFFFFF;
			endcase

			repeat ($urandom_range(50, 30)) begin
				r = $urandom_range(99);
				if (r < 46) begin
					// A search reads every active hole, so each must have been loaded.
					span_now     = (holes_in_use > HOLE_SLOTS) ? HOLE_SLOTS : int'(holes_in_use);
					hole_missing = 1'b0;
					missing_slot = '0;
					for (int i = span_now - 1; i >= 0; i--) begin
						if (!hole_loaded[i]) begin
							hole_missing = 1'b1;
							missing_slot = slot_t'(i);
						end
					end
					if (hole_missing)
						send_request(OP_LOAD, missing_slot, draw_size(), 1'b0, NO_GRANT);
					else
						send_request(OP_ALLOC, slot_t'($urandom), draw_size(), 1'b0, NO_GRANT);
					random_items++;
				end else if (r < 82) begin
					send_request(OP_LOAD, slot_t'($urandom), draw_size(), 1'b0, NO_GRANT);
					random_items++;
				end else if (r < 91) begin
					send_request(OP_FREE, slot_t'($urandom), amount_t'($urandom), 1'b0, NO_GRANT);
					random_items++;
				end else begin
					send_request(OP_NONE, slot_t'($urandom), amount_t'($urandom), 1'b0, NO_GRANT);
					random_items++;
				end
			end
			phase++;
		end

		settle_idle();
		$display("Run took %0d items in %0d phases: %0d allocation requests, %0d granted.",
			items_taken, phase, requests, grants_seen);
		$display("All four policy codes and a spread of hole counts up to 63 were set by %0d writes.",
			reg_writes);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: run did not finish in time, %0d results outstanding", $time,
			pending_grants.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
